// ----- rtl/core/pcp_pkg.sv -----
package pcp_pkg;

    localparam logic [15:0] PI_HALF_Q13 = 16'd12868;
    localparam logic [16:0] TWO_PI_Q13  = 17'd51472;

    localparam logic [1:0] CFG_JUMP   = 2'd0;
    localparam logic [1:0] CFG_HOLD   = 2'd1;
    localparam logic [1:0] CFG_SETTLE = 2'd2;

    localparam int QDEPTH = 2;

    // request handed from the front part to the back part
    typedef struct packed {
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic signed [15:0] h;
        logic               last;
    } pcp_req_t;

    typedef struct packed {
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic        [15:0] heading;
        logic        [31:0] arc;
        logic signed [31:0] kappa;
        logic signed [31:0] rate;
        logic               last;
    } pcp_res_t;

    function automatic logic [15:0] remap_heading(input logic signed [15:0] h);
        logic signed [17:0] v;
        begin
            v = $signed({2'b00, PI_HALF_Q13}) - 18'(h);
            if (v < 0)
                v = v + $signed({1'b0, TWO_PI_Q13});
            if (v >= $signed({1'b0, TWO_PI_Q13}))
                v = v - $signed({1'b0, TWO_PI_Q13});
            remap_heading = v[15:0];
        end
    endfunction

endpackage

// ----- rtl/core/path_curvature_profile.sv -----
// Curvature profile of a sampled path. Points are requests on the input channel;
// each point comes back two requests later, and a point marked last flushes all
// points still held, so a path of N points yields N results. A two-entry queue
// sits in front of a sequencer that shares one bit-serial unit for the square
// root and the divisions. Configuration writes are taken at any time but
// should be made while the block is idle.
module path_curvature_profile
    import pcp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [30:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [23:0] x_position,
    input  logic signed [23:0] y_position,
    input  logic signed [15:0] heading_in,
    input  logic               last_point,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [23:0] x_out,
    output logic signed [23:0] y_out,
    output logic [15:0]        heading_out,
    output logic [31:0]        arc_length,
    output logic signed [31:0] curvature,
    output logic signed [31:0] curvature_rate,
    output logic               last_result
);

    logic [30:0] jump_reg;
    logic [30:0] hold_reg;
    logic [7:0]  settle_reg;
    pcp_req_t    in_req;
    pcp_req_t    q_req;
    logic        q_valid;
    logic        q_ready;
    pcp_res_t    res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            jump_reg   <= 31'd6554;
            hold_reg   <= 31'd32768;
            settle_reg <= 8'd5;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_JUMP:   jump_reg   <= cfg_data;
                CFG_HOLD:   hold_reg   <= cfg_data;
                CFG_SETTLE: settle_reg <= cfg_data[7:0];
                default:    ;
            endcase
        end
    end

    assign in_req = '{x: x_position, y: y_position, h: heading_in, last: last_point};

    pcp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_req   (in_req),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_req    (q_req)
    );

    pcp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_req      (q_req),
        .jump_limit (jump_reg),
        .hold_limit (hold_reg),
        .settle     (settle_reg),
        .res_valid  (out_valid),
        .res_ready  (out_ready),
        .res        (res)
    );

    assign x_out          = res.x;
    assign y_out          = res.y;
    assign heading_out    = res.heading;
    assign arc_length     = res.arc;
    assign curvature      = res.kappa;
    assign curvature_rate = res.rate;
    assign last_result    = res.last;

endmodule

// ----- rtl/core/pcp_front.sv -----
module pcp_front
    import pcp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  pcp_req_t           in_req,
    output logic               q_valid,
    input  logic               q_ready,
    output pcp_req_t           q_req
);

    pcp_req_t                 mem_reg [QDEPTH];
    logic                     wr_ptr_reg;
    logic                     rd_ptr_reg;
    logic [1:0]               cnt_reg;
    logic                     push;
    logic                     pop;

    assign in_ready = (cnt_reg != 2'(QDEPTH));
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_req    = mem_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= in_req;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 2'(QDEPTH)) else $error("queue count overflow");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'(QDEPTH)) |-> !push) else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0) |=> !$fell(cnt_reg == 2'd0) || $past(push))
        else $error("queue count moved without push");

endmodule

// ----- rtl/core/pcp_divsq.sv -----
module pcp_divsq
    import pcp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               is_sqrt,
    input  logic [49:0]        num,
    input  logic [31:0]        den,
    output logic               done,
    output logic [47:0]        quo,
    output logic [48:0]        rem
);

    // shared restoring divider / digit-by-digit square root, one bit a cycle
    // division takes its 48-bit numerator from num[47:0]
    logic [49:0] n_reg;
    logic [48:0] r_reg;
    logic [47:0] q_reg;
    logic [31:0] d_reg;
    logic        sq_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic [49:0] trial;
    logic [48:0] rsh;
    logic [49:0] sub;

    assign quo  = q_reg;
    assign rem  = r_reg;

    always_comb
    begin
        if (sq_reg)
        begin
            rsh = {r_reg[46:0], n_reg[49:48]};
            sub = {q_reg[47:0], 2'b01};
        end
        else
        begin
            rsh = {r_reg[47:0], n_reg[49]};
            sub = {18'd0, d_reg};
        end
        trial = {1'b0, rsh} - sub;
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg  <= is_sqrt ? num : {num[47:0], 2'b00};
            d_reg  <= den;
            sq_reg <= is_sqrt;
            r_reg  <= '0;
            q_reg  <= '0;
        end
        else if (busy_reg)
        begin
            n_reg <= sq_reg ? {n_reg[47:0], 2'b00} : {n_reg[48:0], 1'b0};
            if (!trial[49])
            begin
                r_reg <= trial[48:0];
                q_reg <= {q_reg[46:0], 1'b1};
            end
            else
            begin
                r_reg <= rsh;
                q_reg <= {q_reg[46:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 6'd0;
            done     <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= is_sqrt ? 6'd25 : 6'd48;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy_reg)) else $error("done without work");

endmodule

// ----- rtl/core/pcp_back.sv -----
module pcp_back
    import pcp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    output logic               q_ready,
    input  pcp_req_t           q_req,
    input  logic [30:0]        jump_limit,
    input  logic [30:0]        hold_limit,
    input  logic [7:0]         settle,
    output logic               res_valid,
    input  logic               res_ready,
    output pcp_res_t           res
);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_SQ    = 5'd1;
    localparam logic [4:0] S_SQW   = 5'd2;
    localparam logic [4:0] S_K     = 5'd3;
    localparam logic [4:0] S_KW    = 5'd4;
    localparam logic [4:0] S_FILT  = 5'd5;
    localparam logic [4:0] S_R     = 5'd6;
    localparam logic [4:0] S_RW    = 5'd7;
    localparam logic [4:0] S_EMIT  = 5'd8;
    localparam logic [4:0] S_SHIFT = 5'd9;
    localparam logic [4:0] S_LK    = 5'd10;
    localparam logic [4:0] S_LKW   = 5'd11;
    localparam logic [4:0] S_LFILT = 5'd12;
    localparam logic [4:0] S_LR1   = 5'd13;
    localparam logic [4:0] S_LR1W  = 5'd14;
    localparam logic [4:0] S_LE1   = 5'd15;
    localparam logic [4:0] S_LR2   = 5'd16;
    localparam logic [4:0] S_LR2W  = 5'd17;
    localparam logic [4:0] S_LE2   = 5'd18;
    localparam logic [4:0] S_SOLE  = 5'd19;

    logic [4:0]         st_reg;
    logic signed [23:0] xw_reg [3];
    logic signed [23:0] yw_reg [3];
    logic signed [15:0] hw_reg [3];
    logic [31:0]        aw_reg [3];
    logic signed [31:0] kw_reg [2];
    logic signed [31:0] held_reg;
    logic [15:0]        idx_reg;
    pcp_req_t           cur_reg;
    logic [31:0]        s_reg;
    logic signed [31:0] knew_reg;
    logic signed [31:0] rate_reg;
    logic [31:0]        ds_reg;
    logic               neg_reg;
    logic [47:0]        mag_reg;
    logic               zero_kind_reg;
    logic               res_valid_reg;
    pcp_res_t           res_reg;

    logic               start;
    logic               sq_mode;
    logic [49:0]        num;
    logic [31:0]        den;
    logic               u_done;
    logic [47:0]        u_quo;
    logic [48:0]        u_rem;

    logic signed [24:0] dx;
    logic signed [24:0] dy;
    logic [49:0]        dd;
    logic [32:0]        arc_sum;
    logic signed [31:0] div_sat;
    logic signed [31:0] filt_k;
    logic signed [32:0] fd;
    logic [32:0]        fd_abs;
    logic [32:0]        held_abs;
    logic [15:0]        fidx;

    pcp_divsq u_divsq (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .is_sqrt (sq_mode),
        .num     (num),
        .den     (den),
        .done    (u_done),
        .quo     (u_quo),
        .rem     (u_rem)
    );

    assign dx = 25'(cur_reg.x) - 25'(xw_reg[2]);
    assign dy = 25'(cur_reg.y) - 25'(yw_reg[2]);
    // squared distance needs 49 bits at the coordinate extremes
    assign dd = $unsigned(50'(dx) * 50'(dx)) + $unsigned(50'(dy) * 50'(dy));
    assign arc_sum = {1'b0, aw_reg[2]} + 33'(u_quo[24:0])
                   + 33'(u_rem > {24'd0, u_quo[24:0]});

    // signed value = +/- quotient, saturated; zero spacing per sign of numerator
    always_comb
    begin
        if (zero_kind_reg)
        begin
            if (mag_reg == 48'd0)
                div_sat = 32'sd0;
            else
                div_sat = neg_reg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        else if (neg_reg)
            div_sat = (u_quo > 48'h8000_0000) ? 32'sh8000_0000 : 32'(-$signed({1'b0, u_quo}));
        else
            div_sat = (u_quo > 48'h7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(u_quo);
    end

    always_comb
    begin
        fidx     = (st_reg == S_LFILT) ? idx_reg : idx_reg - 16'd1;
        fd       = 33'(knew_reg) - 33'(held_reg);
        fd_abs   = fd[32] ? 33'(-fd) : 33'(fd);
        held_abs = held_reg[31] ? 33'(-33'(held_reg)) : 33'(held_reg);
        filt_k   = knew_reg;
        if (fidx > 16'(settle) && fd_abs > 33'(jump_limit) && held_abs < 33'(hold_limit))
            filt_k = held_reg;
    end

    // operand set-up for the shared unit
    always_comb
    begin
        start   = 1'b0;
        sq_mode = 1'b0;
        num     = 50'd0;
        den     = 32'd1;
        unique case (st_reg)
            S_SQ:
            begin
                start   = 1'b1;
                sq_mode = 1'b1;
                num     = dd;
            end
            S_K, S_LK, S_R, S_LR1, S_LR2:
            begin
                start = (ds_reg != 32'd0);
                num   = {2'b00, mag_reg};
                den   = ds_reg;
            end
            default:
            begin
                start = 1'b0;
            end
        endcase
    end

    assign q_ready   = (st_reg == S_IDLE) && !res_valid_reg;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    function automatic logic [47:0] mag_of(input logic signed [32:0] v, input logic [3:0] sh);
        logic [32:0] a;
        begin
            a = v[32] ? 33'(-v) : 33'(v);
            mag_of = 48'(a) << sh;
        end
    endfunction

    always_ff @(posedge clk)
    begin
        if (st_reg == S_IDLE && q_valid && !res_valid_reg)
            cur_reg <= q_req;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= S_IDLE;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
            for (int i = 0; i < 3; i++)
            begin
                xw_reg[i] <= '0;
                yw_reg[i] <= '0;
                hw_reg[i] <= '0;
                aw_reg[i] <= '0;
            end
            kw_reg[0]     <= '0;
            kw_reg[1]     <= '0;
            held_reg      <= '0;
            idx_reg       <= '0;
            s_reg         <= '0;
            knew_reg      <= '0;
            rate_reg      <= '0;
            ds_reg        <= '0;
            neg_reg       <= 1'b0;
            mag_reg       <= '0;
            zero_kind_reg <= 1'b0;
        end
        else
        begin
            if (res_valid_reg && res_ready)
                res_valid_reg <= 1'b0;
            unique case (st_reg)
                S_IDLE:
                begin
                    if (q_valid && !res_valid_reg)
                        st_reg <= (idx_reg == 16'd0) ? S_SHIFT : S_SQ;
                    s_reg <= '0;
                end
                S_SQ:
                    st_reg <= S_SQW;
                S_SQW:
                begin
                    if (u_done)
                    begin
                        // saturated arc gives zero spacing afterwards
                        s_reg <= arc_sum[32] ? 32'hFFFF_FFFF : arc_sum[31:0];
                        st_reg <= S_K;
                        if (idx_reg == 16'd1)
                        begin
                            ds_reg  <= (arc_sum[32] ? 32'hFFFF_FFFF : arc_sum[31:0]) - aw_reg[2];
                            neg_reg <= cur_reg.h < hw_reg[2];
                            mag_reg <= mag_of(33'(cur_reg.h) - 33'(hw_reg[2]), 4'd13);
                        end
                        else
                        begin
                            ds_reg  <= (arc_sum[32] ? 32'hFFFF_FFFF : arc_sum[31:0]) - aw_reg[1];
                            neg_reg <= cur_reg.h < hw_reg[1];
                            mag_reg <= mag_of(33'(cur_reg.h) - 33'(hw_reg[1]), 4'd13);
                        end
                    end
                end
                S_K, S_LK, S_R, S_LR1, S_LR2:
                begin
                    zero_kind_reg <= (ds_reg == 32'd0);
                    st_reg <= st_reg + 5'd1;
                end
                S_KW, S_LKW:
                begin
                    if (zero_kind_reg || u_done)
                    begin
                        knew_reg <= div_sat;
                        st_reg   <= (st_reg == S_KW) ? S_FILT : S_LFILT;
                    end
                end
                S_FILT:
                begin
                    held_reg <= filt_k;
                    knew_reg <= filt_k;
                    if (idx_reg >= 16'd2)
                    begin
                        if (idx_reg == 16'd2)
                        begin
                            ds_reg <= aw_reg[2] - aw_reg[1];
                            neg_reg <= (33'(filt_k) - 33'(kw_reg[1])) < 0;
                            mag_reg <= mag_of(33'(filt_k) - 33'(kw_reg[1]), 4'd10);
                        end
                        else
                        begin
                            ds_reg <= aw_reg[2] - aw_reg[0];
                            neg_reg <= (33'(filt_k) - 33'(kw_reg[0])) < 0;
                            mag_reg <= mag_of(33'(filt_k) - 33'(kw_reg[0]), 4'd10);
                        end
                        st_reg <= S_R;
                    end
                    else
                    begin
                        kw_reg[0] <= kw_reg[1];
                        kw_reg[1] <= filt_k;
                        st_reg    <= S_SHIFT;
                    end
                end
                S_RW, S_LR1W, S_LR2W:
                begin
                    if (zero_kind_reg || u_done)
                    begin
                        rate_reg <= zero_kind_reg ? 32'sd0 : div_sat;
                        st_reg   <= st_reg + 5'd1;
                    end
                end
                S_EMIT, S_LE1:
                begin
                    if (!res_valid_reg)
                    begin
                        res_valid_reg   <= 1'b1;
                        res_reg.x       <= xw_reg[1];
                        res_reg.y       <= yw_reg[1];
                        res_reg.heading <= remap_heading(hw_reg[1]);
                        res_reg.arc     <= aw_reg[1];
                        res_reg.kappa   <= kw_reg[1];
                        res_reg.rate    <= rate_reg;
                        res_reg.last    <= 1'b0;
                        if (st_reg == S_EMIT)
                        begin
                            kw_reg[0] <= kw_reg[1];
                            kw_reg[1] <= knew_reg;
                            st_reg    <= S_SHIFT;
                        end
                        else
                        begin
                            ds_reg  <= aw_reg[2] - aw_reg[1];
                            neg_reg <= (33'(knew_reg) - 33'(kw_reg[1])) < 0;
                            mag_reg <= mag_of(33'(knew_reg) - 33'(kw_reg[1]), 4'd10);
                            st_reg  <= S_LR2;
                        end
                    end
                end
                S_SHIFT:
                begin
                    xw_reg[0] <= xw_reg[1];
                    xw_reg[1] <= xw_reg[2];
                    xw_reg[2] <= cur_reg.x;
                    yw_reg[0] <= yw_reg[1];
                    yw_reg[1] <= yw_reg[2];
                    yw_reg[2] <= cur_reg.y;
                    hw_reg[0] <= hw_reg[1];
                    hw_reg[1] <= hw_reg[2];
                    hw_reg[2] <= cur_reg.h;
                    aw_reg[0] <= aw_reg[1];
                    aw_reg[1] <= aw_reg[2];
                    aw_reg[2] <= s_reg;
                    if (cur_reg.last)
                    begin
                        if (idx_reg == 16'd0)
                            st_reg <= S_SOLE;
                        else
                        begin
                            ds_reg  <= s_reg - aw_reg[2];
                            neg_reg <= cur_reg.h < hw_reg[2];
                            mag_reg <= mag_of(33'(cur_reg.h) - 33'(hw_reg[2]), 4'd13);
                            st_reg  <= S_LK;
                        end
                    end
                    else
                    begin
                        if (idx_reg != 16'hFFFF)
                            idx_reg <= idx_reg + 16'd1;
                        st_reg <= S_IDLE;
                    end
                end
                S_LFILT:
                begin
                    held_reg <= filt_k;
                    knew_reg <= filt_k;
                    if (idx_reg == 16'd1)
                    begin
                        ds_reg  <= aw_reg[2] - aw_reg[1];
                        neg_reg <= (33'(filt_k) - 33'(kw_reg[1])) < 0;
                        mag_reg <= mag_of(33'(filt_k) - 33'(kw_reg[1]), 4'd10);
                    end
                    else
                    begin
                        ds_reg  <= aw_reg[2] - aw_reg[0];
                        neg_reg <= (33'(filt_k) - 33'(kw_reg[0])) < 0;
                        mag_reg <= mag_of(33'(filt_k) - 33'(kw_reg[0]), 4'd10);
                    end
                    st_reg <= S_LR1;
                end
                S_LE2, S_SOLE:
                begin
                    if (!res_valid_reg)
                    begin
                        res_valid_reg   <= 1'b1;
                        res_reg.x       <= xw_reg[2];
                        res_reg.y       <= yw_reg[2];
                        res_reg.heading <= remap_heading(hw_reg[2]);
                        res_reg.arc     <= aw_reg[2];
                        res_reg.kappa   <= (st_reg == S_SOLE) ? 32'sd0 : knew_reg;
                        res_reg.rate    <= (st_reg == S_SOLE) ? 32'sd0 : rate_reg;
                        res_reg.last    <= 1'b1;
                        for (int i = 0; i < 3; i++)
                        begin
                            xw_reg[i] <= '0;
                            yw_reg[i] <= '0;
                            hw_reg[i] <= '0;
                            aw_reg[i] <= '0;
                        end
                        kw_reg[0] <= '0;
                        kw_reg[1] <= '0;
                        held_reg  <= '0;
                        idx_reg   <= '0;
                        st_reg    <= S_IDLE;
                    end
                end
                default:
                    st_reg <= S_IDLE;
            endcase
        end
    end

    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_ready |-> (st_reg == S_IDLE)) else $error("request taken while busy");
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res_ready) |=> res_valid_reg && $stable(res_reg))
        else $error("result dropped");
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !$past(res_valid_reg) && res_reg.last) |-> idx_reg == 16'd0)
        else $error("path state not cleared");

endmodule

// ----- dv/path_curvature_profile_test.sv -----
`timescale 1ns / 100ps

module path_curvature_profile_test;
    import pcp_pkg::*;

    typedef struct packed {
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic signed [15:0] h;
        logic               last;
    } point_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [30:0]        cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic signed [23:0] x_position;
    logic signed [23:0] y_position;
    logic signed [15:0] heading_in;
    logic               last_point;
    logic               out_valid;
    logic               out_ready;
    logic signed [23:0] x_out;
    logic signed [23:0] y_out;
    logic [15:0]        heading_out;
    logic [31:0]        arc_length;
    logic signed [31:0] curvature;
    logic signed [31:0] curvature_rate;
    logic               last_result;

    path_curvature_profile i_dut (.*);

    // shadow configuration and path state
    logic [30:0]        jump_lim;
    logic [30:0]        hold_lim;
    logic [7:0]         settle;
    logic signed [23:0] xw [3];
    logic signed [23:0] yw [3];
    logic signed [15:0] hw [3];
    logic [31:0]        sw [3];
    logic signed [31:0] kw [2];
    logic signed [31:0] held_k;
    int unsigned        pidx;

    point_t   pending_points[$];
    pcp_res_t expected_profile[$];
    int       mismatches;
    int       send_idle_pct;
    int       recv_idle_pct;
    bit       stim_done;

    function automatic longint unsigned round_sqrt(input longint unsigned v);
        longint unsigned r, b, rem;
        r = 0;
        b = 64'd1 << 62;
        rem = v;
        while (b > rem) b = b >> 2;
        while (b != 0)
        begin
            if (rem >= r + b)
            begin
                rem = rem - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        if (rem > r) r++;
        return r;
    endfunction

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] kappa_of(input longint da, input logic [31:0] ds);
        if (ds == 0)
            return (da > 0) ? 32'sh7FFFFFFF : (da < 0) ? 32'sh80000000 : 32'sd0;
        return clamp32((da * 8192) / longint'({32'd0, ds}));
    endfunction

    function automatic logic signed [31:0] rate_of(input longint dk, input logic [31:0] ds);
        if (ds == 0) return 0;
        return clamp32((dk * 1024) / longint'({32'd0, ds}));
    endfunction

    function automatic logic signed [31:0] deglitch(input logic signed [31:0] k,
                                                    input int unsigned idx);
        longint d, ah;
        if (idx > settle)
        begin
            d = longint'(k) - longint'(held_k);
            if (d < 0) d = -d;
            ah = (held_k < 0) ? -longint'(held_k) : longint'(held_k);
            if (d > longint'(jump_lim) && ah < longint'(hold_lim)) k = held_k;
        end
        held_k = k;
        return k;
    endfunction

    function automatic void push_result(input int slot, input logic signed [31:0] k,
                                        input logic signed [31:0] r, input logic lst);
        pcp_res_t e;
        int v;
        v = 12868 - int'(hw[slot]);
        if (v < 0) v += 51472;
        if (v >= 51472) v -= 51472;
        e.x = xw[slot];
        e.y = yw[slot];
        e.heading = v[15:0];
        e.arc = sw[slot];
        e.kappa = k;
        e.rate = r;
        e.last = lst;
        expected_profile.push_back(e);
    endfunction

    function automatic void clear_path();
        for (int i = 0; i < 3; i++)
        begin
            xw[i] = 0; yw[i] = 0; hw[i] = 0; sw[i] = 0;
        end
        kw[0] = 0; kw[1] = 0; held_k = 0; pidx = 0;
    endfunction

    function automatic void predict_point(input point_t p);
        int unsigned c;
        logic [31:0] s, ds1;
        longint dx, dy;
        longint unsigned sum;
        logic signed [31:0] knew, r, kl, rp;
        c = pidx;
        s = 0;
        if (c != 0)
        begin
            dx = longint'(p.x) - longint'(xw[2]);
            dy = longint'(p.y) - longint'(yw[2]);
            sum = longint'(sw[2]) + round_sqrt(dx * dx + dy * dy);
            s = (sum > 64'hFFFFFFFF) ? 32'hFFFFFFFF : sum[31:0];
            if (c == 1)
                knew = kappa_of(longint'(p.h) - longint'(hw[2]), s - sw[2]);
            else
                knew = kappa_of(longint'(p.h) - longint'(hw[1]), s - sw[1]);
            knew = deglitch(knew, c - 1);
            if (c >= 2)
            begin
                if (c == 2)
                    r = rate_of(longint'(knew) - longint'(kw[1]), sw[2] - sw[1]);
                else
                    r = rate_of(longint'(knew) - longint'(kw[0]), sw[2] - sw[0]);
                push_result(1, kw[1], r, 1'b0);
            end
            kw[0] = kw[1];
            kw[1] = knew;
        end
        for (int i = 0; i < 2; i++)
        begin
            xw[i] = xw[i+1]; yw[i] = yw[i+1]; hw[i] = hw[i+1]; sw[i] = sw[i+1];
        end
        xw[2] = p.x; yw[2] = p.y; hw[2] = p.h; sw[2] = s;
        if (p.last)
        begin
            if (c == 0)
                push_result(2, 0, 0, 1'b1);
            else
            begin
                ds1 = sw[2] - sw[1];
                kl = deglitch(kappa_of(longint'(hw[2]) - longint'(hw[1]), ds1), c);
                if (c == 1)
                    rp = rate_of(longint'(kl) - longint'(kw[1]), ds1);
                else
                    rp = rate_of(longint'(kl) - longint'(kw[0]), sw[2] - sw[0]);
                push_result(1, kw[1], rp, 1'b0);
                push_result(2, kl, rate_of(longint'(kl) - longint'(kw[1]), ds1), 1'b1);
            end
            clear_path();
        end
        else if (c < 65535)
            pidx = c + 1;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatches++;
        $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_ready)
        begin
            if (pending_points.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                point_t p;
                p = pending_points.pop_front();
                predict_point(p);
                in_valid   <= 1'b1;
                x_position <= p.x;
                y_position <= p.y;
                heading_in <= p.h;
                last_point <= p.last;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_profile.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result with nothing expected", $realtime);
                end
                else
                begin
                    pcp_res_t e;
                    e = expected_profile.pop_front();
                    if (x_out !== e.x) report_mismatch("x_out", x_out, e.x);
                    if (y_out !== e.y) report_mismatch("y_out", y_out, e.y);
                    if (heading_out !== e.heading)
                        report_mismatch("heading_out", heading_out, e.heading);
                    if (arc_length !== e.arc) report_mismatch("arc_length", arc_length, e.arc);
                    if (curvature !== e.kappa) report_mismatch("curvature", curvature, e.kappa);
                    if (curvature_rate !== e.rate)
                        report_mismatch("curvature_rate", curvature_rate, e.rate);
                    if (last_result !== e.last)
                        report_mismatch("last_result", last_result, e.last);
                end
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [30:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_JUMP:   jump_lim = val;
            CFG_HOLD:   hold_lim = val;
            default:    settle = val[7:0];
        endcase
    endtask

    task automatic wait_drained();
        while (pending_points.size() != 0 || in_valid || expected_profile.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    function automatic void add_point(input int x, input int y, input int h, input bit lst);
        point_t p;
        p.x = 24'(x); p.y = 24'(y); p.h = 16'(h); p.last = lst;
        pending_points.push_back(p);
    endfunction

    function automatic int rand_heading();
        return int'($urandom_range(51472)) - 25736;
    endfunction

    // random well-formed path, mostly gentle arcs with the odd glitch
    function automatic void add_path(input int n, input int step_max);
        int x, y, h;
        x = int'($urandom_range(200000)) - 100000;
        y = int'($urandom_range(200000)) - 100000;
        h = rand_heading();
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(9))
                0: ;                                               // repeated point
                1: begin x = int'($urandom) >>> 8; y = int'($urandom) >>> 8; end
                default:
                begin
                    x += int'($urandom_range(2 * step_max)) - step_max;
                    y += int'($urandom_range(2 * step_max)) - step_max;
                end
            endcase
            if (x > 8388607) x = 8388607;
            if (x < -8388608) x = -8388608;
            if (y > 8388607) y = 8388607;
            if (y < -8388608) y = -8388608;
            if ($urandom_range(7) == 0) h = rand_heading();
            else h += int'($urandom_range(200)) - 100;
            if (h > 25736) h = 25736;
            if (h < -25736) h = -25736;
            add_point(x, y, h, i == n - 1);
        end
    endfunction

    task automatic random_phase(input int items);
        int sent, n;
        sent = 0;
        while (sent < items)
        begin
            n = ($urandom_range(9) == 0) ? 1 : int'($urandom_range(2, 14));
            add_path(n, $urandom_range(1) ? 64 : 4096);
            sent += n;
        end
        wait_drained();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0; cfg_index = CFG_JUMP; cfg_data = 0;
        in_valid = 1'b0; x_position = 0; y_position = 0; heading_in = 0; last_point = 0;
        out_ready = 1'b0;
        mismatches = 0;
        stim_done = 0;
        send_idle_pct = 22;
        recv_idle_pct = 78;
        jump_lim = 6554; hold_lim = 32768; settle = 5;
        clear_path();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: single point, extremes, zero spacing, path over extreme corners
        add_point(0, 0, 0, 1'b1);
        add_point(8388607, -8388608, 25736, 1'b1);
        add_point(-8388608, 8388607, -25736, 1'b0);
        add_point(8388607, -8388608, 25736, 1'b1);
        add_point(100, 100, 0, 1'b0);
        add_point(100, 100, 500, 1'b0);
        add_point(100, 100, -500, 1'b0);
        add_point(100, 100, 0, 1'b1);
        for (int i = 0; i < 12; i++)
            add_point(i[0] ? 8388607 : -8388608, i[1] ? 8388607 : -8388608,
                      (i % 3 == 0) ? 25736 : -25736, i == 11);
        add_point(0, 0, 12868, 1'b0);
        add_point(1024, 0, 12868, 1'b1);
        wait_drained();

        random_phase(80);
        write_reg(CFG_JUMP, 31'h7FFFFFFF);
        write_reg(CFG_HOLD, 31'h7FFFFFFF);
        write_reg(CFG_SETTLE, 31'd255);
        random_phase(40);
        write_reg(CFG_JUMP, 31'd0);
        write_reg(CFG_SETTLE, 31'd0);
        send_idle_pct = 78;
        recv_idle_pct = 22;
        random_phase(80);
        write_reg(CFG_HOLD, 31'd0);
        write_reg(CFG_JUMP, 31'd100);
        random_phase(20);
        write_reg(CFG_HOLD, 31'h40000000);
        write_reg(CFG_JUMP, 31'($urandom_range(20000)));
        write_reg(CFG_SETTLE, 31'($urandom_range(1, 4)));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(70);

        if (mismatches == 0 && expected_profile.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #30ms;
        $display("Verification failed");
        $finish;
    end

endmodule
